### sv/pasd_pkg.sv
// pasd_pkg: shared types, constants and codes for the PWM angle steering detector.
// Used by pasd_div, pasd_steer and pwm_angle_steering_detector. No dependencies.
`default_nettype none

package pasd_pkg;

  // angles in hundredths of a degree
  localparam int FULL_TURN = 36000;
  localparam int HALF_TURN = 18000;
  localparam int ANGLE_W   = 16;   // bits to hold FULL_TURN
  localparam int QUOT_W    = 16;   // quotient bits, quotient < FULL_TURN
  localparam int QCNT_W    = 5;    // counts 0..QUOT_W
  localparam int RUN_W     = 8;

  localparam int DEF_CAPTURE_WIDTH = 16;
  localparam int TICK_W            = 16;   // port width of the tick fields

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_TH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_TH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE   = 2'd3;

  localparam logic [14:0]      RST_TURN_TH   = 15'd9000;
  localparam logic [14:0]      RST_CENTER_TH = 15'd3000;
  localparam logic [RUN_W-1:0] RST_STABLE    = 8'd15;

  // steering states
  localparam logic [1:0] MODE_CENTER = 2'd0;
  localparam logic [1:0] MODE_LEFT   = 2'd1;
  localparam logic [1:0] MODE_RIGHT  = 2'd2;

  // steering events
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_LEFT   = 2'd1;
  localparam logic [1:0] EV_RIGHT  = 2'd2;
  localparam logic [1:0] EV_CENTER = 2'd3;

  typedef struct packed {
    logic              sample_new;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] period_ticks;
  } pasd_in_t;

  typedef struct packed {
    logic                      angle_valid;
    logic signed [ANGLE_W-1:0] rel_angle;
    logic [1:0]                steer_state;
    logic [1:0]                steer_event;
  } pasd_out_t;

  typedef struct packed {
    logic             decode_low_time;
    logic [14:0]      turn_threshold;
    logic [14:0]      center_threshold;
    logic [RUN_W-1:0] stable_samples;
  } pasd_cfg_t;

  // update request from the sequencer to the steering logic
  typedef struct packed {
    logic              go;     // commit this poll
    logic              ok;     // sample usable, quot holds the angle
    logic [QUOT_W-1:0] quot;   // high*36000/period
  } pasd_steer_req_t;

endpackage

`default_nettype wire

### sv/pasd_div.sv
// pasd_div: restoring divider, one quotient bit per cycle.
// Depends on pasd_pkg. Numerator must be below divisor * 2^QUOT_W.
`default_nettype none

module pasd_div import pasd_pkg::*; #(
  parameter int CW = DEF_CAPTURE_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [CW+ANGLE_W-1:0]   num,
  input  wire logic [CW-1:0]           divisor,
  output logic                         done,
  output logic [QUOT_W-1:0]            quot
);

  logic [CW-1:0]     rem;
  logic [QUOT_W-1:0] nbits;
  logic [QCNT_W-1:0] cnt;
  logic [CW:0]       trial;
  logic [CW:0]       diff;

  // upper numerator bits are already below the divisor, so they seed the remainder
  assign trial = {rem, nbits[QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign done  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= QCNT_W'(QUOT_W);
    end else if (!done) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[CW+ANGLE_W-1:QUOT_W];
      nbits <= num[QUOT_W-1:0];
    end else if (!done) begin
      nbits <= {nbits[QUOT_W-2:0], 1'b0};
      if (!diff[CW]) begin
        rem  <= diff[CW-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= trial[CW-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

### sv/pasd_steer.sv
// pasd_steer: zero capture, relative angle wrap and centre/left/right debounce.
// Depends on pasd_pkg. Result is combinational on the request; state moves on req.go.
`default_nettype none

module pasd_steer import pasd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pasd_cfg_t       cfg,
  input  wire pasd_steer_req_t req,
  output pasd_out_t            res
);

  logic               zero_set, zero_set_next;
  logic [ANGLE_W-1:0] zero_angle, zero_angle_next;
  logic [1:0]         mode, mode_next;
  logic [RUN_W-1:0]   left_run, left_run_next;
  logic [RUN_W-1:0]   right_run, right_run_next;
  logic [RUN_W-1:0]   center_run, center_run_next;

  logic [RUN_W-1:0]   need;
  logic [ANGLE_W-1:0] ang;
  logic signed [ANGLE_W:0] rel_raw, rel_w, turn_th, center_th;
  logic               valid;
  logic [1:0]         ev;

  localparam logic signed [ANGLE_W:0] HALF_S = (ANGLE_W+1)'(HALF_TURN);
  localparam logic signed [ANGLE_W:0] FULL_S = (ANGLE_W+1)'(FULL_TURN);

  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign need = (cfg.stable_samples == '0) ? RUN_W'(1) : cfg.stable_samples;

  always_comb begin
    ang = req.quot;
    if (cfg.decode_low_time) begin
      // full turn folds to zero
      ang = (req.quot == '0) ? '0 : ANGLE_W'(FULL_TURN) - req.quot;
    end
  end

  assign rel_raw   = $signed({1'b0, ang}) - $signed({1'b0, zero_angle});
  assign turn_th   = $signed({2'b00, cfg.turn_threshold});
  assign center_th = $signed({2'b00, cfg.center_threshold});
  assign valid     = req.ok && zero_set;

  always_comb begin
    if (rel_raw > HALF_S) begin
      rel_w = rel_raw - FULL_S;
    end else if (rel_raw < -HALF_S) begin
      rel_w = rel_raw + FULL_S;
    end else begin
      rel_w = rel_raw;
    end
  end

  always_comb begin
    zero_set_next   = zero_set;
    zero_angle_next = zero_angle;
    mode_next       = mode;
    left_run_next   = left_run;
    right_run_next  = right_run;
    center_run_next = center_run;
    ev              = EV_NONE;
    if (!valid) begin
      left_run_next   = '0;
      right_run_next  = '0;
      center_run_next = '0;
      if (req.ok) begin
        zero_set_next   = 1'b1;
        zero_angle_next = ang;
      end
    end else if (mode == MODE_CENTER) begin
      if (rel_w >= turn_th) begin
        left_run_next  = bump(left_run);
        right_run_next = '0;
      end else if (rel_w <= -turn_th) begin
        right_run_next = bump(right_run);
        left_run_next  = '0;
      end else begin
        left_run_next  = '0;
        right_run_next = '0;
      end
      if (left_run_next >= need) begin
        left_run_next = '0;
        mode_next     = MODE_LEFT;
        ev            = EV_LEFT;
      end else if (right_run_next >= need) begin
        right_run_next = '0;
        mode_next      = MODE_RIGHT;
        ev             = EV_RIGHT;
      end
    end else begin
      if (rel_w <= center_th && rel_w >= -center_th) begin
        center_run_next = bump(center_run);
      end else begin
        center_run_next = '0;
      end
      if (center_run_next >= need) begin
        center_run_next = '0;
        left_run_next   = '0;
        right_run_next  = '0;
        mode_next       = MODE_CENTER;
        ev              = EV_CENTER;
      end
    end
  end

  always_comb begin
    res.angle_valid = valid;
    res.rel_angle   = valid ? rel_w[ANGLE_W-1:0] : '0;
    res.steer_state = mode_next;
    res.steer_event = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_set   <= 1'b0;
      zero_angle <= '0;
      mode       <= MODE_CENTER;
      left_run   <= '0;
      right_run  <= '0;
      center_run <= '0;
    end else if (req.go) begin
      zero_set   <= zero_set_next;
      zero_angle <= zero_angle_next;
      mode       <= mode_next;
      left_run   <= left_run_next;
      right_run  <= right_run_next;
      center_run <= center_run_next;
    end
  end

endmodule

`default_nettype wire

### sv/pwm_angle_steering_detector.sv
// pwm_angle_steering_detector: top level, request sequencer, config registers, output register.
// Depends on pasd_pkg, pasd_div and pasd_steer.
//
// Usage: each input request is one poll (sample_new, high_ticks, period_ticks) on a
// valid/ready channel; each poll yields exactly one result (angle_valid, rel_angle,
// steer_state, steer_event) on the output valid/ready channel.
// A usable sample goes through a multiply step (high * 36000), a load step, the divide
// step (the divider iterations, then a check to see them finish) and an update step
// that updates the steering state and loads the output register, after which out_valid rises.
// An unusable sample skips the multiply and divide and goes straight to the update step.
// in_ready is high only while the sequencer is idle, so one poll is in flight at a time.
// A result sits in the output register until taken; if the receiver stalls, the next
// poll is still accepted and worked on, and holds in its final step until the register
// frees, so no state changes until its result can be stored.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and are to
// be made while the block is idle. Synchronous reset clears the zero capture, the
// steering state and the run counters and restores the register defaults.
`default_nettype none

module pwm_angle_steering_detector import pasd_pkg::*; #(
  parameter int CAPTURE_WIDTH = DEF_CAPTURE_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire pasd_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pasd_out_t                  out_data,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // ticks beyond the port width never reach the block
  localparam int CW = (CAPTURE_WIDTH < TICK_W) ? CAPTURE_WIDTH : TICK_W;
  localparam int NW = CW + ANGLE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;

  logic [2:0]      state, state_next;
  pasd_cfg_t       cfg;
  logic [CW-1:0]   high_r, period_r;
  logic            ok_r;
  logic [NW-1:0]   prod;
  logic            div_done;
  logic [QUOT_W-1:0] quot;
  pasd_steer_req_t sreq;
  pasd_out_t       sres;
  logic            in_take, commit;
  logic [CW-1:0]   high_in, period_in;
  logic            ok_in;

  assign in_ready  = (state == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign commit    = (state == S_POST) && (!out_valid || out_ready);
  assign high_in   = in_data.high_ticks[CW-1:0];
  assign period_in = in_data.period_ticks[CW-1:0];
  // high below period already rules out a zero period
  assign ok_in     = in_data.sample_new && (high_in != '0) && (high_in < period_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decode_low_time  <= 1'b0;
      cfg.turn_threshold   <= RST_TURN_TH;
      cfg.center_threshold <= RST_CENTER_TH;
      cfg.stable_samples   <= RST_STABLE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOW_TIME:  cfg.decode_low_time  <= cfg_data[0];
        REG_TURN_TH:   cfg.turn_threshold   <= cfg_data[14:0];
        REG_CENTER_TH: cfg.center_threshold <= cfg_data[14:0];
        REG_STABLE:    cfg.stable_samples   <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_take) state_next = ok_in ? S_MUL : S_POST;
      S_MUL:  state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_POST;
      S_POST: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      high_r   <= high_in;
      period_r <= period_in;
      ok_r     <= ok_in;
    end
    if (state == S_MUL) begin
      prod <= NW'(high_r) * NW'(FULL_TURN);
    end
  end

  pasd_div #(
    .CW (CW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_LOAD),
    .num     (prod),
    .divisor (period_r),
    .done    (div_done),
    .quot    (quot)
  );

  always_comb begin
    sreq.go   = commit;
    sreq.ok   = ok_r;
    sreq.quot = quot;
  end

  pasd_steer u_steer (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (sreq),
    .res (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= sres;
    end
  end

  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_MUL) || (state == S_POST))
    else $error("accepted request did not start processing");

  a_div_to_post: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_done |=> state == S_POST)
    else $error("divider finish not followed by update step");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST) && out_valid && !out_ready |=> state == S_POST)
    else $error("result committed over a stalled output");

  a_event_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.steer_event != EV_NONE) |-> out_data.angle_valid)
    else $error("steering event on an invalid poll");

  a_state_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.steer_state != 2'd3)
    else $error("unused steering state reported");

endmodule

`default_nettype wire
